[rtl/core/lpe_pkg.sv]
package lpe_pkg;

  localparam int RAW_W  = 16;  // widest sample the command word carries
  localparam int LVL_W  = 16;
  localparam int CNT_W  = 4;
  localparam int POS_W  = 19;
  localparam int WSUM_W = 38;
  localparam int PSUM_W = 19;
  localparam int DIV_W  = 38;  // divider dividend / quotient width
  localparam int DEN_W  = 19;  // divider divisor width
  localparam int STEP_W = 6;

  localparam logic [2:0] OP_TRACK   = 3'd0;
  localparam logic [2:0] OP_DARK    = 3'd1;
  localparam logic [2:0] OP_LIGHT   = 3'd2;
  localparam logic [2:0] OP_MEASURE = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [2:0] REG_LINE_LEVEL = 3'd0;
  localparam logic [2:0] REG_RUG_LEVEL  = 3'd1;
  localparam logic [2:0] REG_TOLERANCE  = 3'd2;
  localparam logic [2:0] REG_LINE_WHITE = 3'd3;
  localparam logic [2:0] REG_SENSOR_CNT = 3'd4;

  typedef enum logic [2:0] {
    K_TRACK,
    K_DARK,
    K_LIGHT,
    K_MEASURE,
    K_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [2:0]       idx;
    logic [RAW_W-1:0] raw;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [LVL_W-1:0] line_level;
    logic [LVL_W-1:0] rug_level;
    logic [LVL_W-1:0] line_tolerance;
    logic             line_is_white;
    logic [CNT_W-1:0] sensor_count;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DEN_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

[rtl/core/lpe_front.sv]
module lpe_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [2:0]             operation,
  input  logic [2:0]             sensor_index,
  input  logic [SAMPLE_BITS-1:0] raw_value,
  input  logic                   last_of_frame,
  output lpe_pkg::cmd_t          head,
  output logic                   head_valid,
  input  logic                   pop
);

  lpe_pkg::cmd_t q0, q1, cmd_in;
  logic [1:0]    count;
  logic          known, push;

  always_comb begin
    known = 1'b1;
    cmd_in.kind = lpe_pkg::K_TRACK;
    case (operation)
      lpe_pkg::OP_TRACK:   cmd_in.kind = lpe_pkg::K_TRACK;
      lpe_pkg::OP_DARK:    cmd_in.kind = lpe_pkg::K_DARK;
      lpe_pkg::OP_LIGHT:   cmd_in.kind = lpe_pkg::K_LIGHT;
      lpe_pkg::OP_MEASURE: cmd_in.kind = lpe_pkg::K_MEASURE;
      lpe_pkg::OP_CLEAR:   cmd_in.kind = lpe_pkg::K_CLEAR;
      default:             known = 1'b0;  // undefined ops are dropped here
    endcase
    cmd_in.idx  = sensor_index;
    cmd_in.raw  = lpe_pkg::RAW_W'(raw_value);
    cmd_in.last = last_of_frame;
  end

  assign sample_stall = (count == 2'd2);
  assign push         = sample_valid && !sample_stall && known;
  assign head         = q0;
  assign head_valid   = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && pop) begin
        if (count == 2'd1) q0 <= cmd_in;
        else begin
          q0 <= q1;
          q1 <= cmd_in;
        end
      end else if (pop) begin
        q0    <= q1;
        count <= count - 2'd1;
      end else if (push) begin
        if (count == 2'd0) q0 <= cmd_in;
        else q1 <= cmd_in;
        count <= count + 2'd1;
      end
    end
  end

endmodule

[rtl/core/lpe_div.sv]
module lpe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  lpe_pkg::div_req_t           req,
  output logic                        done,
  output logic [lpe_pkg::DIV_W-1:0]   quotient
);

  logic [lpe_pkg::DIV_W-1:0]  dvd;
  logic [lpe_pkg::DEN_W:0]    rem, rem_sh;
  logic [lpe_pkg::DEN_W-1:0]  den;
  logic [lpe_pkg::STEP_W-1:0] left;
  logic                       busy, ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh   = {rem[lpe_pkg::DEN_W-1:0], dvd[lpe_pkg::DIV_W-1]};
  assign ge       = (rem_sh >= {1'b0, den});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
        left <= req.steps;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
        dvd  <= {dvd[lpe_pkg::DIV_W-2:0], ge};
        left <= left - 1'b1;
        if (left == lpe_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/lpe_back.sv]
module lpe_back #(
  parameter int MAX_SENSORS = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpe_pkg::cfg_t                 cfg,
  input  lpe_pkg::cmd_t                 head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [lpe_pkg::POS_W-1:0]     position,
  output logic                          line_seen,
  output logic                          calibration_error
);

  localparam int IDXW  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNTW  = $clog2(MAX_SENSORS + 1);
  localparam int NUM_W = SAMPLE_BITS + 16;  // |raw-lo| * |span| fits here
  localparam int PRD_W = SAMPLE_BITS + 18;
  localparam int FULLW = CNTW + lpe_pkg::LVL_W;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;
  localparam logic [lpe_pkg::POS_W-1:0] PMAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_FIX, S_PROD1, S_PROD2, S_ACC, S_FINAL, S_FDIV, S_RES
  } state_t;

  state_t state;

  logic [SAMPLE_BITS-1:0] max_store [MAX_SENSORS];
  logic [SAMPLE_BITS-1:0] min_store [MAX_SENSORS];

  lpe_pkg::cmd_t                 cur;
  logic signed [PRD_W-1:0]       prod;
  logic                          neg;
  logic [lpe_pkg::LVL_W-1:0]     x;
  logic [31:0]                   p1;
  logic [35:0]                   p2;
  logic [lpe_pkg::WSUM_W-1:0]    wsum;
  logic [lpe_pkg::PSUM_W-1:0]    psum;
  logic                          seen, err;
  logic [lpe_pkg::POS_W-1:0]     last_pos;
  lpe_pkg::div_req_t             div_req;
  logic                          div_done;
  logic [lpe_pkg::DIV_W-1:0]     div_q;

  // combinational helpers
  logic [4:0]              idx5, sc5, cnt5;
  logic [CNTW-1:0]         cnt;
  logic [IDXW-1:0]         addr;
  logic                    in_store, in_cnt;
  logic [SAMPLE_BITS-1:0]  raw, lo_rd, hi_rd;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [16:0]      span;
  logic [lpe_pkg::LVL_W-1:0] out_lo;
  logic [PRD_W-1:0]        prod_abs;
  logic [NUM_W-1:0]        mag;
  logic signed [NUM_W:0]   qs;
  logic signed [NUM_W+1:0] v, v1, rug_ext, line_ext;
  logic [FULLW-1:0]        full;
  logic [lpe_pkg::POS_W-1:0] full_sat, q_sat;

  always_comb begin
    idx5     = {2'b00, head.idx};
    sc5      = {1'b0, cfg.sensor_count};
    if (sc5 == 5'd0) cnt5 = 5'd1;
    else if (sc5 > 5'(MAX_SENSORS)) cnt5 = 5'(MAX_SENSORS);
    else cnt5 = sc5;
    cnt      = cnt5[CNTW-1:0];
    addr     = idx5[IDXW-1:0];
    in_store = (idx5 < 5'(MAX_SENSORS));
    in_cnt   = (idx5 < cnt5);
    raw      = head.raw[SAMPLE_BITS-1:0];
    lo_rd    = min_store[addr];
    hi_rd    = max_store[addr];
    diff     = $signed({1'b0, raw}) - $signed({1'b0, lo_rd});
    span     = cfg.line_is_white ? ($signed({1'b0, cfg.rug_level}) - $signed({1'b0, cfg.line_level}))
                                 : ($signed({1'b0, cfg.line_level}) - $signed({1'b0, cfg.rug_level}));
    out_lo   = cfg.line_is_white ? cfg.line_level : cfg.rug_level;
    prod_abs = prod[PRD_W-1] ? PRD_W'(-prod) : PRD_W'(prod);
    mag      = prod_abs[NUM_W-1:0];
    qs       = neg ? -$signed({1'b0, div_q[NUM_W-1:0]}) : $signed({1'b0, div_q[NUM_W-1:0]});
    rug_ext  = $signed((NUM_W+2)'(cfg.rug_level));
    line_ext = $signed((NUM_W+2)'(cfg.line_level));
    v        = $signed({qs[NUM_W], qs}) + $signed((NUM_W+2)'(out_lo));
    v1       = (v < rug_ext) ? rug_ext : v;
    full     = FULLW'(cnt * cfg.line_level);
    full_sat = (full > FULLW'(PMAX)) ? PMAX : lpe_pkg::POS_W'(full);
    q_sat    = (div_q > lpe_pkg::DIV_W'(PMAX)) ? PMAX : div_q[lpe_pkg::POS_W-1:0];
  end

  assign pop = (state == S_IDLE) && head_valid;

  lpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      div_req.start <= 1'b0;
      wsum          <= '0;
      psum          <= '0;
      seen          <= 1'b0;
      err           <= 1'b0;
      last_pos      <= '0;
      for (int i = 0; i < MAX_SENSORS; i++) begin
        max_store[i] <= '0;
        min_store[i] <= SMAX;
      end
    end else begin
      div_req.start <= 1'b0;
      if (result_valid && !result_stall && state != S_RES) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur <= head;
            case (head.kind)
              lpe_pkg::K_TRACK: begin
                if (in_store) begin
                  if (raw > hi_rd) max_store[addr] <= raw;
                  if (raw < lo_rd) min_store[addr] <= raw;
                end
              end
              lpe_pkg::K_DARK: begin
                if (in_store) max_store[addr] <= raw;
              end
              lpe_pkg::K_LIGHT: begin
                if (in_store) min_store[addr] <= raw;
              end
              lpe_pkg::K_CLEAR: begin
                for (int i = 0; i < MAX_SENSORS; i++) begin
                  max_store[i] <= '0;
                  min_store[i] <= SMAX;
                end
              end
              lpe_pkg::K_MEASURE: begin
                if (in_cnt) begin
                  if (lo_rd >= hi_rd) begin
                    err   <= 1'b1;
                    x     <= cfg.rug_level;
                    state <= S_PROD1;
                  end else begin
                    prod  <= PRD_W'(diff * span);
                    state <= S_MUL;
                  end
                end else if (head.last) begin
                  state <= S_FINAL;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          neg              <= prod[PRD_W-1];
          div_req.start    <= 1'b1;
          div_req.dividend <= lpe_pkg::DIV_W'(mag) << (lpe_pkg::DIV_W - NUM_W);
          div_req.divisor  <= lpe_pkg::DEN_W'(max_store[cur.idx[IDXW-1:0]]
                                              - min_store[cur.idx[IDXW-1:0]]);
          div_req.steps    <= lpe_pkg::STEP_W'(NUM_W);
          state            <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_FIX;
        end
        S_FIX: begin
          x     <= (v1 > line_ext) ? cfg.line_level : v1[lpe_pkg::LVL_W-1:0];
          state <= S_PROD1;
        end
        S_PROD1: begin
          p1    <= x * cfg.line_level;
          state <= S_PROD2;
        end
        S_PROD2: begin
          p2    <= p1 * ({1'b0, cur.idx} + 4'd1);
          state <= S_ACC;
        end
        S_ACC: begin
          wsum  <= wsum + lpe_pkg::WSUM_W'(p2);
          psum  <= psum + lpe_pkg::PSUM_W'(x);
          if (x > cfg.line_tolerance) seen <= 1'b1;
          state <= cur.last ? S_FINAL : S_IDLE;
        end
        S_FINAL: begin
          if (seen) begin
            if (psum != '0) begin
              div_req.start    <= 1'b1;
              div_req.dividend <= wsum;
              div_req.divisor  <= psum;
              div_req.steps    <= lpe_pkg::STEP_W'(lpe_pkg::DIV_W);
              state            <= S_FDIV;
            end else begin
              state <= S_RES;
            end
          end else begin
            last_pos <= (FULLW'(last_pos) < (full >> 1)) ? lpe_pkg::POS_W'(cfg.line_level)
                                                          : full_sat;
            state    <= S_RES;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            last_pos <= q_sat;
            state    <= S_RES;
          end
        end
        S_RES: begin
          if (!result_valid || !result_stall) begin
            result_valid      <= 1'b1;
            position          <= last_pos;
            line_seen         <= seen;
            calibration_error <= err;
            wsum              <= '0;
            psum              <= '0;
            seen              <= 1'b0;
            err               <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/line_position_estimator_core.sv]
// Line position estimator for a reflectance sensor array.
// Sample channel (sample_valid/sample_stall): one raw reading per transaction with
// operation, sensor_index and last_of_frame. Operations track min/max, set dark or
// light references, measure, or clear calibration. Codes 5..7 are accepted and dropped.
// Result channel (result_valid/result_stall): one transaction per frame, issued after
// the measure sample that carries last_of_frame.
// Config port: cfg_write with cfg_index/cfg_data. The user must write it only while the
// block is idle; the block itself does not enforce this. Calibration ops complete in
// the back end's idle state. A measure sample runs one multiply, the SAMPLE_BITS+16
// step normalize division in the shared radix-2 divider, clamp, two multiplies and
// accumulate; bad calibration skips to the multiplies at rug level. A frame end with
// a line seen and psum nonzero runs the 38 step weighted-mean division. The front end
// queues two transactions, so stall shows only when both slots wait on the back end.
// Reset: config returns to defaults, calibration stores clear, accumulators and the
// queue empty, result_valid drops. A stalled result holds; the back end waits to
// load the next one until it is taken, while the queue accepts until both slots fill.
module line_position_estimator_core #(
  parameter int MAX_SENSORS = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [2:0]             operation,
  input  logic [2:0]             sensor_index,
  input  logic [SAMPLE_BITS-1:0] raw_value,
  input  logic                   last_of_frame,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [18:0]            position,
  output logic                   line_seen,
  output logic                   calibration_error
);

  lpe_pkg::cfg_t cfg;
  lpe_pkg::cmd_t head;
  logic          head_valid, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_level     <= 16'd1000;
      cfg.rug_level      <= 16'd0;
      cfg.line_tolerance <= 16'd300;
      cfg.line_is_white  <= 1'b0;
      cfg.sensor_count   <= 4'd8;
    end else if (cfg_write) begin
      case (cfg_index)
        lpe_pkg::REG_LINE_LEVEL: cfg.line_level     <= cfg_data;
        lpe_pkg::REG_RUG_LEVEL:  cfg.rug_level      <= cfg_data;
        lpe_pkg::REG_TOLERANCE:  cfg.line_tolerance <= cfg_data;
        lpe_pkg::REG_LINE_WHITE: cfg.line_is_white  <= cfg_data[0];
        lpe_pkg::REG_SENSOR_CNT: cfg.sensor_count   <= cfg_data[3:0];
        default: ;  // writes past the register list are ignored
      endcase
    end
  end

  // front: classify and queue
  lpe_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .operation     (operation),
    .sensor_index  (sensor_index),
    .raw_value     (raw_value),
    .last_of_frame (last_of_frame),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop)
  );

  // back: calibration stores, normalize, accumulate, frame result
  lpe_back #(.MAX_SENSORS(MAX_SENSORS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .head              (head),
    .head_valid        (head_valid),
    .pop               (pop),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .position          (position),
    .line_seen         (line_seen),
    .calibration_error (calibration_error)
  );

endmodule

[rtl/core/lpe_checker.sv]
module lpe_checker #(
  parameter int SAMPLE_BITS = 12
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   sample_valid,
  input logic                   sample_stall,
  input logic [2:0]             operation,
  input logic [2:0]             sensor_index,
  input logic [SAMPLE_BITS-1:0] raw_value,
  input logic                   last_of_frame,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic [18:0]            position,
  input logic                   line_seen,
  input logic                   calibration_error
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(position) && $stable(line_seen)
                                     && $stable(calibration_error))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(operation)
                                     && $stable(sensor_index) && $stable(raw_value)
                                     && $stable(last_of_frame))
    else $error("stalled sample changed");

  a_rst_res: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_rst_stall: assert property (@(posedge clk) rst |=> !sample_stall)
    else $error("queue not empty after reset");

endmodule

bind line_position_estimator_core lpe_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lpe_checker (.*);
